// ===== src/usvg_pkg.sv =====
// ----------------------------------------------------------------------------
// usvg_pkg
// Shared types, constants and arithmetic helpers of the UV sphere vertex
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package usvg_pkg;

	// configuration register indexes
	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_SEGS   = 1'b1;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// sin/cos unit latency and back pipeline depth (sin/cos, product, output)
	localparam int unsigned SC_LAT     = 11;
	localparam int unsigned BACK_DEPTH = SC_LAT + 2;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic signed [65:0] Q30_ONE = 66'sd1073741824;

	// series divisors: five for the sine chain, then six for the cosine chain
	localparam int unsigned NUM_K     = 11;
	localparam int unsigned SIN_STEPS = 5;
	localparam int unsigned COS_STEPS = 6;
	localparam logic [7:0] DIV_K [NUM_K] = '{
		8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
		8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
	};
	localparam logic [31:0] RECIP [NUM_K] = '{
		32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd72),
		32'(64'd4294967296 / 64'd42),  32'(64'd4294967296 / 64'd20),
		32'(64'd4294967296 / 64'd6),   32'(64'd4294967296 / 64'd132),
		32'(64'd4294967296 / 64'd90),  32'(64'd4294967296 / 64'd56),
		32'(64'd4294967296 / 64'd30),  32'(64'd4294967296 / 64'd12),
		32'(64'd4294967296 / 64'd2)
	};

	typedef struct packed {
		logic [31:0] theta;
		logic [31:0] phi;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic        pole;
	} angle_req_t;

	typedef struct packed {
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic        pole;
	} side_t;

	typedef struct packed {
		logic signed [31:0] sn;
		logic signed [31:0] cs;
	} sincos_t;

	typedef struct packed {
		logic [16:0] pos_x;
		logic [16:0] pos_y;
		logic [16:0] pos_z;
		logic [15:0] norm_x;
		logic [15:0] norm_y;
		logic [15:0] norm_z;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [15:0] tan_x;
		logic [15:0] tan_y;
		logic [15:0] tan_z;
	} vertex_t;

	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] q;
	} div_t;

	// eight quotient bits of a long division by seg, remainder below seg
	function automatic div_t div8(input logic [7:0] rem, input logic [7:0] seg);
		div_t       res;
		logic [8:0] t;
		logic       b;
		res.rem = rem;
		res.q   = 8'd0;
		for (int i = 0; i < 8; i++) begin
			t = {res.rem, 1'b0};
			b = (t >= {1'b0, seg});
			if (b)
				t = t - {1'b0, seg};
			res.rem = t[7:0];
			res.q   = {res.q[6:0], b};
		end
		return res;
	endfunction

	// shift right with rounding to nearest, ties away from zero
	function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
			input int unsigned n);
		logic [65:0] mag;
		logic [65:0] half;
		logic [65:0] m;
		half = 66'd1 << (n - 1);
		mag  = v[65] ? 66'(-v) : 66'(v);
		m    = (mag + half) >> n;
		return v[65] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [65:0] clamp66(input logic signed [65:0] v,
			input logic signed [65:0] lo, input logic signed [65:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [15:0] to_q15(input logic signed [31:0] v);
		logic signed [65:0] r;
		r = clamp66(rnd_shift(66'(v), 15), -66'sd32767, 66'sd32767);
		return r[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/usvg_front.sv =====
// ----------------------------------------------------------------------------
// usvg_front
// Accepts grid points, saturates indices and runs a four stage long division
// by the segment count to form both angles in turns and the texture coords.
// ----------------------------------------------------------------------------
`default_nettype none

module usvg_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [7:0]            seg,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            lat_index,
	input  wire logic [7:0]            lon_index,
	output logic                       push,
	output usvg_pkg::angle_req_t       push_data,
	input  wire logic                  full
);

	logic       adv;
	logic [7:0] seg_e;
	logic [7:0] lat_c, lon_c;
	logic       lat_top, lon_top;
	usvg_pkg::div_t dl1, dn1, dl2, dn2, dl3, dn3, dl4, dn4;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [8:0]  qlat_s1, qlon_s1;
	logic [16:0] qlat_s2, qlon_s2;
	logic [24:0] qlat_s3, qlon_s3;
	logic [32:0] qlat_s4, qlon_s4;
	logic [7:0]  rlat_s1, rlon_s1, rlat_s2, rlon_s2, rlat_s3, rlon_s3, rlon_s4;
	logic        pole_s1, pole_s2, pole_s3, pole_s4;
	logic        round_bit;

	assign adv      = !full;
	assign in_ready = adv;
	assign seg_e    = (seg == 8'd0) ? 8'd1 : seg;

	always_comb begin
		lat_c   = (lat_index > seg_e) ? seg_e : lat_index;
		lon_c   = (lon_index > seg_e) ? seg_e : lon_index;
		lat_top = (lat_c == seg_e);
		lon_top = (lon_c == seg_e);
		dl1 = usvg_pkg::div8(lat_top ? 8'd0 : lat_c, seg_e);
		dn1 = usvg_pkg::div8(lon_top ? 8'd0 : lon_c, seg_e);
		dl2 = usvg_pkg::div8(rlat_s1, seg_e);
		dn2 = usvg_pkg::div8(rlon_s1, seg_e);
		dl3 = usvg_pkg::div8(rlat_s2, seg_e);
		dn3 = usvg_pkg::div8(rlon_s2, seg_e);
		dl4 = usvg_pkg::div8(rlat_s3, seg_e);
		dn4 = usvg_pkg::div8(rlon_s3, seg_e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qlat_s1 <= {lat_top, dl1.q};
			qlon_s1 <= {lon_top, dn1.q};
			rlat_s1 <= dl1.rem;
			rlon_s1 <= dn1.rem;
			pole_s1 <= (lat_c == 8'd0) || lat_top;
			qlat_s2 <= {qlat_s1, dl2.q};
			qlon_s2 <= {qlon_s1, dn2.q};
			rlat_s2 <= dl2.rem;
			rlon_s2 <= dn2.rem;
			pole_s2 <= pole_s1;
			qlat_s3 <= {qlat_s2, dl3.q};
			qlon_s3 <= {qlon_s2, dn3.q};
			rlat_s3 <= dl3.rem;
			rlon_s3 <= dn3.rem;
			pole_s3 <= pole_s2;
			qlat_s4 <= {qlat_s3, dl4.q};
			qlon_s4 <= {qlon_s3, dn4.q};
			rlon_s4 <= dn4.rem;
			pole_s4 <= pole_s3;
		end
	end

	// round phi up when the leftover is at least half a step
	assign round_bit = ({rlon_s4, 1'b0} >= {1'b0, seg_e});

	assign push = v_s4 && adv;

	always_comb begin
		push_data.theta = qlat_s4[32:1] + {31'd0, qlat_s4[0]};
		push_data.phi   = qlon_s4[31:0] + {31'd0, round_bit};
		push_data.tex_u = qlon_s4[32:16] + {16'd0, qlon_s4[15]};
		push_data.tex_v = qlat_s4[32:16] + {16'd0, qlat_s4[15]};
		push_data.pole  = pole_s4;
	end

endmodule

`default_nettype wire

// ===== src/usvg_fifo.sv =====
// ----------------------------------------------------------------------------
// usvg_fifo
// Short register queue of angle requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module usvg_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire usvg_pkg::angle_req_t  push_data,
	input  wire logic                  pop,
	output usvg_pkg::angle_req_t       head,
	output logic                       empty,
	output logic                       full
);

	usvg_pkg::angle_req_t mem_q [usvg_pkg::FIFO_DEPTH];
	logic [usvg_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [usvg_pkg::FIFO_CW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == usvg_pkg::FIFO_CW'(usvg_pkg::FIFO_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== src/usvg_sincos.sv =====
// ----------------------------------------------------------------------------
// usvg_sincos
// Pipelined sine and cosine of an angle in turns (Q0.32) by a folded
// quarter-turn series, giving signed Q2.30 results after eleven stages.
// ----------------------------------------------------------------------------
`default_nettype none

module usvg_sincos (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [31:0]       angle,
	output usvg_pkg::sincos_t      result
);

	localparam int unsigned NK = usvg_pkg::NUM_K;
	localparam int unsigned NC = usvg_pkg::COS_STEPS;

	logic [60:0] p1;
	logic [61:0] p2;
	logic [63:0] p3 [NK];
	logic [39:0] r4 [NK];

	logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4;
	logic [30:0] x_s1, x_s2, x_s3, x_s4;
	logic [31:0] x2_s2, x2_s3;
	logic [31:0] qa_s3 [NK];
	logic [31:0] q_s4  [NK];

	// series chain, one step per stage (stages 5 to 10)
	logic signed [32:0] ys_s5 [NC];
	logic signed [32:0] yc_s5 [NC];
	logic [31:0]        qp_s5 [NC][NK];
	logic [30:0]        xp_s5 [NC];
	logic [1:0]         quadp_s5 [NC];

	logic signed [32:0] ys_in [NC];
	logic signed [32:0] yc_in [NC];
	logic [31:0]        qin   [NC][NK];
	logic signed [32:0] ys_nx [NC];
	logic signed [32:0] yc_nx [NC];
	logic signed [65:0] prs   [NC];
	logic signed [65:0] prc   [NC];

	logic signed [65:0] pr_fin;
	logic signed [65:0] s_fin, c_fin;
	logic signed [31:0] s_v, c_v;

	always_comb begin
		p1 = 61'(angle[29:0]) * 61'(usvg_pkg::HALF_PI_Q30);
		p2 = 62'(x_s1) * 62'(x_s1);
		for (int k = 0; k < NK; k++) begin
			p3[k] = 64'(x2_s2) * 64'(usvg_pkg::RECIP[k]);
			r4[k] = 40'(x2_s3) - 40'(qa_s3[k]) * 40'(usvg_pkg::DIV_K[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= angle[31:30];
			x_s1    <= 31'((p1 + 61'(30'h20000000)) >> 30);
			quad_s2 <= quad_s1;
			x_s2    <= x_s1;
			x2_s2   <= 32'((p2 + 62'(30'h20000000)) >> 30);
			quad_s3 <= quad_s2;
			x_s3    <= x_s2;
			x2_s3   <= x2_s2;
			quad_s4 <= quad_s3;
			x_s4    <= x_s3;
			for (int k = 0; k < NK; k++) begin
				qa_s3[k] <= p3[k][63:32];
				// reciprocal estimate is low by at most one
				q_s4[k]  <= qa_s3[k] +
					{31'd0, (r4[k] >= 40'(usvg_pkg::DIV_K[k]))};
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NC; j++) begin
			if (j == 0) begin
				ys_in[j] = 33'sd1073741824;
				yc_in[j] = 33'sd1073741824;
				for (int k = 0; k < NK; k++)
					qin[j][k] = q_s4[k];
			end else begin
				ys_in[j] = ys_s5[j-1];
				yc_in[j] = yc_s5[j-1];
				for (int k = 0; k < NK; k++)
					qin[j][k] = qp_s5[j-1][k];
			end
			prc[j]   = 66'($signed({1'b0, qin[j][usvg_pkg::SIN_STEPS + j]})) * 66'(yc_in[j]);
			yc_nx[j] = 33'(usvg_pkg::Q30_ONE - usvg_pkg::rnd_shift(prc[j], 30));
			if (j < usvg_pkg::SIN_STEPS) begin
				prs[j]   = 66'($signed({1'b0, qin[j][j]})) * 66'(ys_in[j]);
				ys_nx[j] = 33'(usvg_pkg::Q30_ONE - usvg_pkg::rnd_shift(prs[j], 30));
			end else begin
				prs[j]   = '0;
				ys_nx[j] = ys_in[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NC; j++) begin
				ys_s5[j]    <= ys_nx[j];
				yc_s5[j]    <= yc_nx[j];
				qp_s5[j]    <= qin[j];
				xp_s5[j]    <= (j == 0) ? x_s4 : xp_s5[j-1];
				quadp_s5[j] <= (j == 0) ? quad_s4 : quadp_s5[j-1];
			end
		end
	end

	always_comb begin
		pr_fin = 66'($signed({2'b00, xp_s5[NC-1]})) * 66'(ys_s5[NC-1]);
		s_fin  = usvg_pkg::clamp66(usvg_pkg::rnd_shift(pr_fin, 30), '0,
			usvg_pkg::Q30_ONE);
		c_fin  = usvg_pkg::clamp66(66'(yc_s5[NC-1]), '0, usvg_pkg::Q30_ONE);
		s_v    = s_fin[31:0];
		c_v    = c_fin[31:0];
	end

	// fold the quarter turn back into the full circle
	always_ff @(posedge clk) begin
		if (en) begin
			case (quadp_s5[NC-1])
				2'd0: begin
					result.sn <= s_v;
					result.cs <= c_v;
				end
				2'd1: begin
					result.sn <= c_v;
					result.cs <= -s_v;
				end
				2'd2: begin
					result.sn <= -s_v;
					result.cs <= -c_v;
				end
				default: begin
					result.sn <= -c_v;
					result.cs <= s_v;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/usvg_back.sv =====
// ----------------------------------------------------------------------------
// usvg_back
// Takes angle requests from the queue, evaluates both angles, forms the
// direction and drives the vertex output register.
// ----------------------------------------------------------------------------
`default_nettype none

module usvg_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [15:0]           radius,
	input  wire logic                  empty,
	input  wire usvg_pkg::angle_req_t  head,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output usvg_pkg::vertex_t          vertex
);

	localparam int unsigned D = usvg_pkg::BACK_DEPTH;
	localparam int unsigned L = usvg_pkg::SC_LAT;

	logic adv;
	logic v_q [D];
	usvg_pkg::side_t   side_q [L + 1];
	usvg_pkg::side_t   side_in;
	usvg_pkg::sincos_t sc_th, sc_ph;

	logic signed [31:0] d0_s12, d1_s12, d2_s12, sp_s12, cp_s12;
	logic signed [65:0] pd0, pd2;
	logic signed [65:0] pp0, pp1, pp2;
	logic signed [65:0] pos0, pos1, pos2;

	assign adv       = !v_q[D-1] || out_ready;
	assign pop       = adv && !empty;
	assign out_valid = v_q[D-1];

	assign side_in = '{tex_u: head.tex_u, tex_v: head.tex_v, pole: head.pole};

	usvg_sincos u_theta (
		.clk    (clk),
		.en     (adv),
		.angle  (head.theta),
		.result (sc_th)
	);

	usvg_sincos u_phi (
		.clk    (clk),
		.en     (adv),
		.angle  (head.phi),
		.result (sc_ph)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++)
				v_q[i] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= pop;
			for (int i = 1; i < D; i++)
				v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_in;
			for (int i = 1; i <= L; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	always_comb begin
		pd0 = 66'(sc_th.sn) * 66'(sc_ph.cs);
		pd2 = 66'(sc_th.sn) * 66'(sc_ph.sn);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d0_s12 <= 32'(usvg_pkg::rnd_shift(pd0, 30));
			d1_s12 <= sc_th.cs;
			d2_s12 <= 32'(usvg_pkg::rnd_shift(pd2, 30));
			sp_s12 <= sc_ph.sn;
			cp_s12 <= sc_ph.cs;
		end
	end

	always_comb begin
		pp0  = 66'($signed({1'b0, radius})) * 66'(d0_s12);
		pp1  = 66'($signed({1'b0, radius})) * 66'(d1_s12);
		pp2  = 66'($signed({1'b0, radius})) * 66'(d2_s12);
		pos0 = usvg_pkg::clamp66(usvg_pkg::rnd_shift(pp0, 30), -66'sd65535, 66'sd65535);
		pos1 = usvg_pkg::clamp66(usvg_pkg::rnd_shift(pp1, 30), -66'sd65535, 66'sd65535);
		pos2 = usvg_pkg::clamp66(usvg_pkg::rnd_shift(pp2, 30), -66'sd65535, 66'sd65535);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vertex.pos_x  <= pos0[16:0];
			vertex.pos_y  <= pos1[16:0];
			vertex.pos_z  <= pos2[16:0];
			vertex.norm_x <= usvg_pkg::to_q15(d0_s12);
			vertex.norm_y <= usvg_pkg::to_q15(d1_s12);
			vertex.norm_z <= usvg_pkg::to_q15(d2_s12);
			vertex.tex_u  <= side_q[L].tex_u;
			vertex.tex_v  <= side_q[L].tex_v;
			vertex.tan_y  <= 16'd0;
			// poles point the tangent along x by cos theta
			if (side_q[L].pole) begin
				vertex.tan_x <= usvg_pkg::to_q15(d1_s12);
				vertex.tan_z <= 16'd0;
			end else begin
				vertex.tan_x <= usvg_pkg::to_q15(-sp_s12);
				vertex.tan_z <= usvg_pkg::to_q15(cp_s12);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/uv_sphere_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Gives the position, normal, texture coordinates and tangent of one UV
// sphere grid point per request.
// ----------------------------------------------------------------------------
//
// channel    dir   handshake            payload
// s_*        in    s_tvalid/s_tready    lat_index, lon_index
// m_*        out   m_tvalid/m_tready    vertex fields
// wr_*       in    wr_en                wr_index, wr_data
//
// One request per cycle sustained while m_tready is high; the path runs through four
// long-division stages in the front, one queue slot, eleven sin/cos stages, one product
// stage and the output register.
// Reset sets radius 256 and 16 segments and empties the queue and pipelines.
// A stalled output holds the back; the front runs on until its four-entry
// queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_vertex_generator (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic         wr_index,
	input  wire logic [15:0]  wr_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// lat_index[7:0], lon_index[15:8]
	input  wire logic [15:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// pos_x, pos_y, pos_z (17 each), norm_x, norm_y, norm_z (16 each),
	// tex_u, tex_v (17 each), tan_x, tan_y, tan_z (16 each), zero pad
	output logic [183:0]      m_tdata
);

	logic [15:0] radius_q;
	logic [7:0]  seg_q;

	logic                 push, pop, empty, full;
	usvg_pkg::angle_req_t push_data, head;
	usvg_pkg::vertex_t    vertex;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			seg_q    <= 8'd16;
		end else if (wr_en) begin
			case (wr_index)
				usvg_pkg::REG_RADIUS: radius_q <= wr_data;
				usvg_pkg::REG_SEGS:   seg_q    <= wr_data[7:0];
				default:              seg_q    <= seg_q;
			endcase
		end
	end

	usvg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (seg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.lat_index (s_tdata[7:0]),
		.lon_index (s_tdata[15:8]),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	usvg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	usvg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.radius    (radius_q),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.vertex    (vertex)
	);

	assign m_tdata = {3'b000,
		vertex.tan_z, vertex.tan_y, vertex.tan_x,
		vertex.tex_v, vertex.tex_u,
		vertex.norm_z, vertex.norm_y, vertex.norm_x,
		vertex.pos_z, vertex.pos_y, vertex.pos_x};

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams UV sphere grid points into the vertex generator under random
// source and sink stalls, predicts each vertex in fixed point and compares
// every field of every returned vertex in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int SEG_LIMIT = 255;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint HALF_PI = 64'sd1686629713;
	localparam int LATENCY = 18;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [16:0] pos_x, pos_y, pos_z;
		logic [15:0] norm_x, norm_y, norm_z;
		logic [16:0] tex_u, tex_v;
		logic [15:0] tan_x, tan_y, tan_z;
	} vertex_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic wr_index = 1'b0;
	logic [15:0] wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [183:0] m_tdata;

	uv_sphere_vertex_generator dut (.*);

	logic [15:0] grid_pending[$];
	vertex_rec_t vertex_expected[$];
	longint radius_now = 256;
	longint segs_now = 16;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit src_hold = 1'b0;
	bit in_taken = 1'b0;
	int mismatches = 0;
	int vertices_seen = 0;
	longint cycles = 0;

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint rnd30(longint v);
		if (v < 0)
			return -((-v + (64'sd1 << 29)) >>> 30);
		return (v + (64'sd1 << 29)) >>> 30;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [15:0] q15_of(longint v);
		longint r;
		r = v < 0 ? -((-v + 16384) >>> 15) : ((v + 16384) >>> 15);
		return 16'(clip(r, -32767, 32767));
	endfunction

	// series sin/cos over one turn given as Q0.32
	task automatic turn_trig(input logic [31:0] t, output longint sn, output longint cs);
		longint sdiv[5] = '{110, 72, 42, 20, 6};
		longint cdiv[6] = '{132, 90, 56, 30, 12, 2};
		longint x, x2, y, s, c;
		x = ((longint'(t[29:0]) * HALF_PI) + (64'sd1 << 29)) >>> 30;
		x2 = rnd30(x * x);
		y = ONE_Q30;
		foreach (sdiv[i]) y = ONE_Q30 - rnd30((x2 / sdiv[i]) * y);
		s = clip(rnd30(x * y), 0, ONE_Q30);
		y = ONE_Q30;
		foreach (cdiv[i]) y = ONE_Q30 - rnd30((x2 / cdiv[i]) * y);
		c = clip(y, 0, ONE_Q30);
		case (t[31:30])
			2'd0: begin sn = s; cs = c; end
			2'd1: begin sn = c; cs = -s; end
			2'd2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
	endtask

	task automatic predict_vertex(input logic [7:0] lat_in, input logic [7:0] lon_in);
		vertex_rec_t v;
		longint seg, lat, lon, st, ct, sp, cp;
		longint d[3];
		logic [16:0] p[3];
		logic [15:0] n[3];
		logic [31:0] tt, tp;
		seg = clip(segs_now, 1, SEG_LIMIT);
		lat = lat_in > seg ? seg : lat_in;
		lon = lon_in > seg ? seg : lon_in;
		tt = 32'(((lat << 32) + seg) / (2 * seg));
		tp = 32'(((lon << 33) + seg) / (2 * seg));
		turn_trig(tt, st, ct);
		turn_trig(tp, sp, cp);
		d[0] = rnd30(st * cp);
		d[1] = ct;
		d[2] = rnd30(st * sp);
		for (int i = 0; i < 3; i++) begin
			p[i] = 17'(clip(rnd30(radius_now * d[i]), -65535, 65535));
			n[i] = q15_of(d[i]);
		end
		v.pos_x = p[0]; v.pos_y = p[1]; v.pos_z = p[2];
		v.norm_x = n[0]; v.norm_y = n[1]; v.norm_z = n[2];
		v.tex_u = 17'((lon * 131072 + seg) / (2 * seg));
		v.tex_v = 17'((lat * 131072 + seg) / (2 * seg));
		v.tan_y = '0;
		if (lat == 0 || lat == seg) begin
			v.tan_x = q15_of(ct);
			v.tan_z = '0;
		end else begin
			v.tan_x = q15_of(-sp);
			v.tan_z = q15_of(cp);
		end
		vertex_expected.insert(vertex_expected.size(), v);
	endtask

	task automatic report_mismatch(input string what, input logic [16:0] got,
			input logic [16:0] want);
		mismatches++;
		$display("tb: vertex %0d %s got %0h want %0h", vertices_seen, what, got, want);
	endtask

	// driver: advance only after the request was taken at the last rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (!src_hold && grid_pending.size() > 0 &&
						$urandom_range(99) >= src_idle_pct) begin
					s_tdata <= grid_pending.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= $urandom_range(99) >= snk_idle_pct;
		end
	end

	always @(posedge clk) begin
		in_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			predict_vertex(s_tdata[7:0], s_tdata[15:8]);
	end

	// monitor
	always @(posedge clk) begin
		vertex_rec_t g, w;
		if (m_tvalid && m_tready) begin
			{g.pos_x, g.pos_y, g.pos_z, g.norm_x, g.norm_y, g.norm_z,
				g.tex_u, g.tex_v, g.tan_x, g.tan_y, g.tan_z} = {
				m_tdata[16:0], m_tdata[33:17], m_tdata[50:34], m_tdata[66:51],
				m_tdata[82:67], m_tdata[98:83], m_tdata[115:99], m_tdata[132:116],
				m_tdata[148:133], m_tdata[164:149], m_tdata[180:165]};
			if (vertex_expected.size() == 0) begin
				report_mismatch("unexpected", 0, 0);
			end else begin
				w = vertex_expected.pop_front();
				if (g.pos_x !== w.pos_x) report_mismatch("pos_x", g.pos_x, w.pos_x);
				if (g.pos_y !== w.pos_y) report_mismatch("pos_y", g.pos_y, w.pos_y);
				if (g.pos_z !== w.pos_z) report_mismatch("pos_z", g.pos_z, w.pos_z);
				if (g.norm_x !== w.norm_x) report_mismatch("norm_x", g.norm_x, w.norm_x);
				if (g.norm_y !== w.norm_y) report_mismatch("norm_y", g.norm_y, w.norm_y);
				if (g.norm_z !== w.norm_z) report_mismatch("norm_z", g.norm_z, w.norm_z);
				if (g.tex_u !== w.tex_u) report_mismatch("tex_u", g.tex_u, w.tex_u);
				if (g.tex_v !== w.tex_v) report_mismatch("tex_v", g.tex_v, w.tex_v);
				if (g.tan_x !== w.tan_x) report_mismatch("tan_x", g.tan_x, w.tan_x);
				if (g.tan_y !== w.tan_y) report_mismatch("tan_y", g.tan_y, w.tan_y);
				if (g.tan_z !== w.tan_z) report_mismatch("tan_z", g.tan_z, w.tan_z);
			end
			vertices_seen++;
		end
	end

	task automatic drain();
		while (grid_pending.size() > 0 || s_tvalid || vertex_expected.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == usvg_pkg::REG_RADIUS)
			radius_now = val;
		else
			segs_now = val[7:0];
	endtask

	task automatic queue_grid(input logic [7:0] lat, input logic [7:0] lon);
		grid_pending.insert(grid_pending.size(), {lon, lat});
	endtask

	// mostly in-range points, some beyond the segment count
	task automatic queue_random(input int count);
		int lim;
		for (int i = 0; i < count; i++) begin
			lim = segs_now == 0 ? 1 : int'(segs_now);
			if ($urandom_range(9) < 8)
				queue_grid(8'($urandom_range(lim)), 8'($urandom_range(lim)));
			else
				queue_grid(8'($urandom_range(255)), 8'($urandom_range(255)));
		end
	endtask

	initial begin
		logic [15:0] radii[6] = '{16'd1, 16'd65535, 16'd256, 16'd0, 16'd1000, 16'd32768};
		logic [7:0] segs[6] = '{8'd1, 8'd255, 8'd16, 8'd0, 8'd7, 8'd200};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, poles, seam, out-of-range indices
		src_idle_pct = 32;
		snk_idle_pct = 65;
		queue_grid(0, 0);
		queue_grid(16, 16);
		queue_grid(8, 0);
		queue_grid(8, 4);
		queue_grid(8, 8);
		queue_grid(8, 12);
		queue_grid(0, 5);
		queue_grid(16, 5);
		queue_grid(255, 255);
		queue_grid(17, 200);
		queue_grid(3, 255);
		queue_grid(8'haa, 8'h55);
		queue_grid(8'h55, 8'haa);
		queue_grid(5, 11);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(usvg_pkg::REG_RADIUS, radii[ph]);
			write_reg(usvg_pkg::REG_SEGS, {8'd0, segs[ph]});
			src_idle_pct = ph < 2 ? 32 : (ph < 4 ? 65 : 0);
			snk_idle_pct = ph < 2 ? 65 : (ph < 4 ? 32 : 0);
			queue_random(48);
			if (ph == 2) begin
				// hold the source part way through until the pipe is empty
				while (grid_pending.size() > 24) @(posedge clk);
				src_hold = 1'b1;
				while (s_tvalid || vertex_expected.size() > 0) @(posedge clk);
				src_hold = 1'b0;
			end
			queue_random(48);
			drain();
		end

		$display("tb: %0d vertices checked over %0d radius/segment settings", vertices_seen, 7);
		$display("tb: poles, seam, saturated indices, zero radius and zero segments covered");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
